[design/sbr_pkg.sv]
// shared types and constants of the sbus frame receiver
`timescale 1ns / 1ps

package sbr_pkg;

    localparam int BYTE_BITS = 8;
    localparam int CH_BITS   = 11;
    localparam int IDX_BITS  = 4;
    localparam int ACC_BITS  = CH_BITS + BYTE_BITS - 1;
    localparam int CNT_BITS  = 5;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [BYTE_BITS-1:0]    byte_t;
    typedef logic [CH_BITS-1:0]      chan_value_t;
    typedef logic [IDX_BITS-1:0]     chan_index_t;
    typedef logic [ACC_BITS-1:0]     acc_t;
    typedef logic [CNT_BITS-1:0]     bit_cnt_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_START_VALUE = 2'd0;
    localparam cfg_index_t REG_END_MASK    = 2'd1;
    localparam cfg_index_t REG_END_VALUE   = 2'd2;

    localparam byte_t START_VALUE_RESET = 8'h0f;
    localparam byte_t END_MASK_RESET    = 8'h04;
    localparam byte_t END_VALUE_RESET   = 8'h00;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_COLLECT,
        ST_FETCH,
        ST_MERGE,
        ST_SEND
    } state_t;

endpackage

[design/sbr_if.sv]
// valid/ready channel interfaces for received bytes and decoded channels
`timescale 1ns / 1ps

interface sbr_byte_if;
    logic           valid;
    logic           ready;
    sbr_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbr_chan_if;
    logic                 valid;
    logic                 ready;
    sbr_pkg::chan_index_t channel_index;
    sbr_pkg::chan_value_t channel_value;
    logic                 last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_channel, output ready);
endinterface

[design/sbus_frame_receiver.sv]
// sbus frame receiver: start byte hunt, data byte store, end check, channel unpacking
// framing takes one byte per cycle while bytes are offered; the end byte is the last
// byte taken for a frame. after a good frame the run unpacks channels from the data
// store: each data byte takes one single-port store read and one accumulator merge,
// and each channel is registered for output in a send step; no byte is taken during
// a run. reset returns to start byte hunt with default registers; the data store is
// not cleared, positions past the stored data bytes read as zero
`timescale 1ns / 1ps

module sbus_frame_receiver #(
    parameter int FRAME_BYTES   = 25,
    parameter int CHANNEL_COUNT = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    sbr_byte_if.sink            rx,
    sbr_chan_if.source          ch,
    input  logic                cfg_we,
    input  sbr_pkg::cfg_index_t cfg_index,
    input  sbr_pkg::byte_t      cfg_data
);
    import sbr_pkg::*;

    localparam int STORE_BYTES = (CHANNEL_COUNT * CH_BITS + 7) / 8;
    localparam int DATA_BYTES  = FRAME_BYTES - 2;
    localparam int MEM_DEPTH   = (STORE_BYTES < DATA_BYTES) ? STORE_BYTES : DATA_BYTES;
    localparam int MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int ADDR_W      = $clog2(STORE_BYTES + 1);

    byte_t start_value_reg;
    byte_t end_mask_reg;
    byte_t end_value_reg;

    state_t state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    acc_t acc_reg, acc_next;
    bit_cnt_t cnt_reg, cnt_next;
    chan_index_t emit_index_reg, emit_index_next;

    byte_t mem [MEM_DEPTH];
    byte_t rd_data_reg;
    logic rd_ok_reg;

    logic out_valid_reg, out_valid_next;
    chan_index_t out_index_reg;
    chan_value_t out_value_reg;
    logic out_last_reg;

    logic rx_fire;
    logic out_free;
    logic at_end;
    logic end_match;
    logic [POS_W-1:0] wr_idx;
    logic wr_en;
    logic rd_in_range;
    byte_t merge_byte;
    acc_t merged_acc;
    bit_cnt_t merged_cnt;
    bit_cnt_t sent_cnt;
    logic last_emit;
    logic load_out;

    assign rx.ready  = (state_reg == ST_HUNT) || (state_reg == ST_COLLECT);
    assign rx_fire   = rx.valid && rx.ready;
    assign out_free  = !out_valid_reg || ch.ready;
    assign at_end    = pos_reg >= POS_W'(FRAME_BYTES - 1);
    assign end_match = (rx.rx_byte & end_mask_reg) == end_value_reg;
    assign wr_idx    = pos_reg - POS_W'(1);
    assign wr_en     = (state_reg == ST_COLLECT) && rx_fire && !at_end
                       && (wr_idx < POS_W'(MEM_DEPTH));
    assign rd_in_range = addr_reg < ADDR_W'(MEM_DEPTH);

    // positions past the last stored byte contribute zero bits
    assign merge_byte = rd_ok_reg ? rd_data_reg : '0;
    assign merged_acc = acc_reg | (acc_t'(merge_byte) << cnt_reg);
    assign merged_cnt = cnt_reg + bit_cnt_t'(BYTE_BITS);
    assign sent_cnt   = cnt_reg - bit_cnt_t'(CH_BITS);
    assign last_emit  = emit_index_reg == IDX_BITS'(CHANNEL_COUNT - 1);
    assign load_out   = (state_reg == ST_SEND) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= START_VALUE_RESET;
            end_mask_reg    <= END_MASK_RESET;
            end_value_reg   <= END_VALUE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_VALUE: start_value_reg <= cfg_data;
                REG_END_MASK:    end_mask_reg    <= cfg_data;
                REG_END_VALUE:   end_value_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (rx_fire && rx.rx_byte == start_value_reg)
                    state_next = ST_COLLECT;
            end
            ST_COLLECT:
            begin
                if (rx_fire && at_end)
                    state_next = end_match ? ST_FETCH : ST_HUNT;
            end
            ST_FETCH:
                state_next = ST_MERGE;
            ST_MERGE:
                state_next = (merged_cnt >= bit_cnt_t'(CH_BITS)) ? ST_SEND : ST_FETCH;
            ST_SEND:
            begin
                if (out_free)
                begin
                    if (last_emit)
                        state_next = ST_HUNT;
                    else if (sent_cnt >= bit_cnt_t'(CH_BITS))
                        state_next = ST_SEND;
                    else
                        state_next = ST_FETCH;
                end
            end
            default:
                state_next = ST_HUNT;
        endcase
    end

    // datapath updates
    always_comb
    begin
        pos_next        = pos_reg;
        addr_next       = addr_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        emit_index_next = emit_index_reg;
        out_valid_next  = out_valid_reg && !ch.ready;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (rx_fire && rx.rx_byte == start_value_reg)
                    pos_next = POS_W'(1);
            end
            ST_COLLECT:
            begin
                if (rx_fire)
                begin
                    if (at_end)
                    begin
                        pos_next        = '0;
                        addr_next       = '0;
                        acc_next        = '0;
                        cnt_next        = '0;
                        emit_index_next = '0;
                    end
                    else
                        pos_next = pos_reg + POS_W'(1);
                end
            end
            ST_FETCH: ;
            ST_MERGE:
            begin
                acc_next  = merged_acc;
                cnt_next  = merged_cnt;
                addr_next = addr_reg + ADDR_W'(1);
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    acc_next        = acc_reg >> CH_BITS;
                    cnt_next        = sent_cnt;
                    emit_index_next = last_emit ? '0 : emit_index_reg + IDX_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_HUNT;
            pos_reg        <= '0;
            addr_reg       <= '0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            emit_index_reg <= '0;
            out_valid_reg  <= 1'b0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            addr_reg       <= addr_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            emit_index_reg <= emit_index_next;
            out_valid_reg  <= out_valid_next;
            if (state_reg == ST_FETCH)
                rd_ok_reg <= rd_in_range;
        end
    end

    // data store: written while framing, read while unpacking, never both
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx[MEM_AW-1:0]] <= rx.rx_byte;
        if (state_reg == ST_FETCH && rd_in_range)
            rd_data_reg <= mem[addr_reg[MEM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_index_reg <= emit_index_reg;
            out_value_reg <= acc_reg[CH_BITS-1:0];
            out_last_reg  <= last_emit;
        end
    end

    assign ch.valid         = out_valid_reg;
    assign ch.channel_index = out_index_reg;
    assign ch.channel_value = out_value_reg;
    assign ch.last_channel  = out_last_reg;

endmodule

[design/sbr_checker.sv]
// port-level assertions for the sbus frame receiver and their bind
`timescale 1ns / 1ps

module sbr_checker #(
    parameter int CHANNEL_COUNT = 12
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 rx_ready,
    input logic                 ch_valid,
    input logic                 ch_ready,
    input sbr_pkg::chan_index_t channel_index,
    input sbr_pkg::chan_value_t channel_value,
    input logic                 last_channel
);
    import sbr_pkg::*;

    // a stalled channel transfer holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid && !ch_ready |=> ch_valid && $stable(channel_index)
            && $stable(channel_value) && $stable(last_channel))
        else $error("stalled channel payload changed");

    // no byte is taken while a run is still going
    a_no_rx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid && !last_channel |-> !rx_ready)
        else $error("byte input open during channel run");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid |-> channel_index <= IDX_BITS'(CHANNEL_COUNT - 1))
        else $error("channel index out of range");

    a_last_marker: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid |-> last_channel == (channel_index == IDX_BITS'(CHANNEL_COUNT - 1)))
        else $error("last marker not on final channel");

endmodule

bind sbus_frame_receiver sbr_checker #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_sbr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_ready      (rx.ready),
    .ch_valid      (ch.valid),
    .ch_ready      (ch.ready),
    .channel_index (ch.channel_index),
    .channel_value (ch.channel_value),
    .last_channel  (ch.last_channel)
);
